[rtl/nc3_pkg.sv]
// shared types, constants and helpers of the normalized 3x3 convolution unit
`timescale 1ns / 1ps
package nc3_pkg;
	localparam int MAX_WIDTH  = 2048;
	localparam int COEFF_BITS = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int PIX_W      = 24;
	localparam int LINE_W     = 2 * PIX_W;
	localparam int ACC_W      = COEFF_BITS + 12;
	localparam int DIV_W      = COEFF_BITS + 4;
	localparam int DCNT_W     = $clog2(ACC_W + 1);
	localparam int TAPS       = 9;
	localparam int TAP_W      = 4;
	localparam int GEO_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_MARGIN = 3'd5;

	typedef struct packed {
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [10:0] centre_column;
		logic [15:0] centre_row;
		logic        filtered;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_MAC,
		ST_START,
		ST_DIV,
		ST_PUSH
	} state_t;

	function automatic logic signed [COEFF_BITS-1:0] coeff(
		input logic [CFG_DATA_W-1:0] row_reg,
		input int k
	);
		logic [CFG_DATA_W+3*COEFF_BITS-1:0] ext;
		ext = {{(3*COEFF_BITS){1'b0}}, row_reg};
		return ext[k*COEFF_BITS +: COEFF_BITS];
	endfunction
endpackage

[rtl/nc3_line_mem.sv]
// line stores: upper and lower rows side by side in one synchronous memory
`timescale 1ns / 1ps
module nc3_line_mem (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [nc3_pkg::COL_W-1:0] rd_addr,
	output logic [nc3_pkg::LINE_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [nc3_pkg::COL_W-1:0] wr_addr,
	input  logic [nc3_pkg::LINE_W-1:0] wr_data
);
	import nc3_pkg::*;

	logic [LINE_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[rtl/nc3_div.sv]
// iterative restoring divider, three channel quotients over one shared divisor
`timescale 1ns / 1ps
module nc3_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [nc3_pkg::ACC_W-1:0] dividend [3],
	input  logic [nc3_pkg::DIV_W-1:0] divisor,
	output logic [nc3_pkg::ACC_W-1:0] quotient [3],
	output logic                     done
);
	import nc3_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_W-1:0]  rem_q [3];
	logic [ACC_W-1:0]  num_q [3];
	logic [DIV_W:0]    trial [3];
	logic [DIV_W:0]    diff [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], num_q[c][ACC_W-1]};
			diff[c]  = trial[c] - {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= DCNT_W'(ACC_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= '0;
				num_q[c] <= dividend[c];
			end
		end else if (cnt_q != '0) begin
			for (int c = 0; c < 3; c++) begin
				if (!diff[c][DIV_W]) begin
					rem_q[c] <= diff[c][DIV_W-1:0];
					num_q[c] <= {num_q[c][ACC_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= trial[c][DIV_W-1:0];
					num_q[c] <= {num_q[c][ACC_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quotient = num_q;
endmodule

[rtl/normalized_3x3_convolution_unit.sv]
// top level: raster counters, 3x3 window, multiply-accumulate, result register
`timescale 1ns / 1ps
// One pixel item is taken at a time. An item that gives no result passes ST_READ only, a
// passed-through centre ST_READ, ST_EVAL and ST_PUSH, and a filtered centre also ST_MAC
// (nine taps through one multiply-accumulate per channel), ST_START and ST_DIV (a 20-step
// divider shared by the three channels); ST_PUSH waits on the output stall. The two line
// stores share one synchronous memory of MAX_WIDTH entries, read when the item is taken and
// written back the next cycle; they are undefined after reset and need no clearing pass.
module normalized_3x3_convolution_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  nc3_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output nc3_pkg::out_item_t            out_item,
	input  logic                          cfg_we,
	input  logic [nc3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nc3_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nc3_pkg::*;

	logic [23:0] ktop_q, kmid_q, kbot_q;
	logic [11:0] width_q;
	logic [15:0] height_q;
	logic [10:0] margin_q;

	state_t state_q, state_d;

	logic [COL_W-1:0] col_q, cur_col_q;
	logic [15:0]      row_q, cur_row_q;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] win_q [TAPS];
	logic             filt_q;
	logic [TAP_W-1:0] tap_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic signed [DIV_W-1:0] ksum_q;
	logic [7:0]       res_q [3];
	logic             out_valid_q;
	out_item_t        out_q;

	logic [GEO_W-1:0] w17, h17, m17;
	logic             take;
	logic [LINE_W-1:0] rd_data;

	logic [GEO_W-1:0] col_a, row_t, row_a, col_n, row_n;
	logic [GEO_W-1:0] cx, cy;
	logic             emit_c, filt_c;

	logic signed [COEFF_BITS-1:0] kv [TAPS];
	logic signed [COEFF_BITS-1:0] kv_sel;
	logic [PIX_W-1:0]             win_sel;
	logic signed [COEFF_BITS+8:0] prod [3];
	logic signed [DIV_W-1:0]      ksum_c;

	logic [ACC_W-1:0] dividend [3];
	logic [DIV_W-1:0] divisor;
	logic [ACC_W-1:0] quotient [3];
	logic             div_done;
	logic             out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktop_q   <= 24'd0;
			kmid_q   <= 24'd256;
			kbot_q   <= 24'd0;
			width_q  <= 12'd640;
			height_q <= 16'd480;
			margin_q <= 11'd70;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KERNEL_TOP:    ktop_q   <= cfg_data;
				REG_KERNEL_MIDDLE: kmid_q   <= cfg_data;
				REG_KERNEL_BOTTOM: kbot_q   <= cfg_data;
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[11:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[15:0];
				REG_BORDER_MARGIN: margin_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	always_comb begin
		if (width_q < 12'd3) begin
			w17 = GEO_W'(3);
		end else if (GEO_W'(width_q) > GEO_W'(MAX_WIDTH)) begin
			w17 = GEO_W'(MAX_WIDTH);
		end else begin
			w17 = GEO_W'(width_q);
		end
		h17 = (height_q < 16'd3) ? GEO_W'(3) : GEO_W'(height_q);
		m17 = GEO_W'(margin_q);
	end

	assign take     = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// position of the item being taken and the counters after it
	always_comb begin
		if (GEO_W'(col_q) >= w17) begin
			col_a = '0;
			row_t = GEO_W'(row_q) + 1'b1;
		end else begin
			col_a = GEO_W'(col_q);
			row_t = GEO_W'(row_q);
		end
		row_a = (row_t >= h17) ? '0 : row_t;
		col_n = col_a + 1'b1;
		row_n = row_a + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (col_n >= w17) begin
				col_q <= '0;
				row_q <= (row_n >= h17) ? 16'd0 : row_n[15:0];
			end else begin
				col_q <= col_n[COL_W-1:0];
				row_q <= row_a[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_col_q <= col_a[COL_W-1:0];
			cur_row_q <= row_a[15:0];
			pix_q     <= in_item;
		end
	end

	nc3_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (col_a[COL_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (state_q == ST_READ),
		.wr_addr (cur_col_q),
		.wr_data ({rd_data[PIX_W-1:0], pix_q})
	);

	// centre position and filter region
	always_comb begin
		cx     = GEO_W'(cur_col_q) - 1'b1;
		cy     = GEO_W'(cur_row_q) - 1'b1;
		emit_c = (cur_row_q >= 16'd2) && (GEO_W'(cur_col_q) >= GEO_W'(2));
		filt_c = (cx >= m17) && (cy >= m17) && (m17 <= w17) && (m17 <= h17) &&
			(cx <= w17 - m17) && (cy <= h17 - m17);
	end

	// window: upper row from the upper store, middle from the lower, bottom is the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (state_q == ST_READ) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= rd_data[LINE_W-1:PIX_W];
			win_q[5] <= rd_data[PIX_W-1:0];
			win_q[8] <= pix_q;
		end
	end

	// kernel taps and their sum
	always_comb begin
		ksum_c = '0;
		for (int t = 0; t < 3; t++) begin
			kv[t]   = coeff(ktop_q, t);
			kv[3+t] = coeff(kmid_q, t);
			kv[6+t] = coeff(kbot_q, t);
		end
		for (int i = 0; i < TAPS; i++) begin
			ksum_c = ksum_c + DIV_W'(kv[i]);
		end
		if (ksum_c == '0) begin
			ksum_c = DIV_W'(1);
		end
	end

	assign kv_sel  = kv[tap_q];
	assign win_sel = win_q[tap_q];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = kv_sel * $signed({1'b0, win_sel[8*c +: 8]});
		end
	end

	// magnitudes into the divider
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dividend[c] = acc_q[c][ACC_W-1] ? ACC_W'(-acc_q[c]) : ACC_W'(acc_q[c]);
		end
		divisor = ksum_q[DIV_W-1] ? DIV_W'(-ksum_q) : DIV_W'(ksum_q);
	end

	nc3_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	assign out_free = !out_valid_q || !out_stall;

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_READ: begin
				filt_q <= filt_c;
			end
			ST_EVAL: begin
				ksum_q <= ksum_c;
				tap_q  <= '0;
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= '0;
					res_q[c] <= win_q[4][8*c +: 8];
				end
			end
			ST_MAC: begin
				tap_q <= tap_q + 1'b1;
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= acc_q[c] + ACC_W'(prod[c]);
				end
			end
			ST_DIV: begin
				if (div_done) begin
					for (int c = 0; c < 3; c++) begin
						if (acc_q[c][ACC_W-1] ^ ksum_q[DIV_W-1]) begin
							res_q[c] <= 8'd0;
						end else if (quotient[c] > ACC_W'(255)) begin
							res_q[c] <= 8'd255;
						end else begin
							res_q[c] <= quotient[c][7:0];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (take) state_d = ST_READ;
			ST_READ: begin
				state_d = emit_c ? ST_EVAL : ST_IDLE;
			end
			ST_EVAL:  state_d = filt_q ? ST_MAC : ST_PUSH;
			ST_MAC:   if (tap_q == TAP_W'(TAPS - 1)) state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_PUSH;
			ST_PUSH:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			out_q.red_out       <= res_q[0];
			out_q.green_out     <= res_q[1];
			out_q.blue_out      <= res_q[2];
			out_q.centre_column <= 11'(cx);
			out_q.centre_row    <= cy[15:0];
			out_q.filtered      <= filt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule
